>>> src/ean8_pkg.sv
// Shared types, constants and code tables for the EAN-8 pixel generator.
package ean8_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic RegQuietWidth  = 1'b0;
  localparam logic RegModuleWidth = 1'b1;

  localparam logic [7:0] QuietReset  = 8'd0;
  localparam logic [4:0] ModuleReset = 5'd1;
  localparam logic [4:0] ModuleMax   = 5'd16;
  localparam logic [6:0] SymModules  = 7'd67;

  typedef struct packed {
    logic [3:0]  digit_0;
    logic [3:0]  digit_1;
    logic [3:0]  digit_2;
    logic [3:0]  digit_3;
    logic [3:0]  digit_4;
    logic [3:0]  digit_5;
    logic [3:0]  digit_6;
    logic [3:0]  digit_7;
    logic [10:0] column;
  } in_item_t;

  typedef struct packed {
    logic pixel;
    logic check_ok;
    logic in_symbol;
    logic out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [7:0] quiet_width;
    logic [4:0] module_width;
  } cfg_t;

  // L-code pattern, leftmost module in bit 6
  function automatic logic [6:0] lcode(input logic [3:0] d);
    logic [6:0] r;
    case (d)
      4'd0:    r = 7'b0001101;
      4'd1:    r = 7'b0011001;
      4'd2:    r = 7'b0010011;
      4'd3:    r = 7'b0111101;
      4'd4:    r = 7'b0100011;
      4'd5:    r = 7'b0110001;
      4'd6:    r = 7'b0101111;
      4'd7:    r = 7'b0111011;
      4'd8:    r = 7'b0110111;
      4'd9:    r = 7'b0001011;
      default: r = 7'b0000000;
    endcase
    return r;
  endfunction

  // ceil(2^16 / w) for w in 1..16
  function automatic logic [16:0] recip16(input logic [4:0] w);
    logic [16:0] r;
    case (w)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21846;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13108;
      5'd6:    r = 17'd10923;
      5'd7:    r = 17'd9363;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7282;
      5'd10:   r = 17'd6554;
      5'd11:   r = 17'd5958;
      5'd12:   r = 17'd5462;
      5'd13:   r = 17'd5042;
      5'd14:   r = 17'd4682;
      5'd15:   r = 17'd4370;
      5'd16:   r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

>>> src/ean8_barcode_pixel_generator_top.sv
// Top level of the EAN-8 barcode pixel generator: three-stage pixel pipeline.
//
// One beat in, one beat out: each accepted identifier/column beat yields one pixel beat,
// and a new beat is accepted every cycle while the pipeline has room. Stage 1
// decodes the column against the quiet zone and symbol bounds and sums the weighted
// digits, stage 2 turns the symbol offset into a module number with a reciprocal
// multiply by the module width, and stage 3 looks up the module's bar and finishes the
// check digit. Each stage holds its beat under output backpressure, and empty stages
// fill up, so input stalls only when all three are full. Configure quiet_width
// (offset 0x0) and module_width (offset 0x4) only while no beats are in flight.
module ean8_barcode_pixel_generator_top import ean8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  cfg_t cfg;

  ean8_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------- stage 1 ----------------
  logic [4:0]  mw_eff;
  logic [10:0] sym_w;
  logic [10:0] sym_end;
  logic [11:0] total;
  logic        oor_d, insym_d, ok_d;
  logic [7:0]  sum_d;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;

  logic [31:0] dig1_q, dig2_q;
  logic        ok1_q, ok2_q;
  logic [7:0]  sum1_q, sum2_q;
  logic [10:0] off1_q;
  logic [4:0]  mw1_q;
  logic        insym1_q, insym2_q, oor1_q, oor2_q;
  logic [27:0] prod_mod;
  logic [15:0] prod_ten;
  logic [4:0]  q10_q;
  logic [6:0]  mod_q;
  out_item_t   out_q, out_d;

  always_comb begin
    if (cfg.module_width == 5'd0) begin
      mw_eff = 5'd1;
    end else if (cfg.module_width > ModuleMax) begin
      mw_eff = ModuleMax;
    end else begin
      mw_eff = cfg.module_width;
    end
    sym_w   = 11'(mw_eff) * 11'(SymModules);
    sym_end = 11'(cfg.quiet_width) + sym_w;
    total   = 12'(sym_end) + 12'(cfg.quiet_width);
    oor_d   = 12'(in_data_i.column) >= total;
    insym_d = !oor_d && (in_data_i.column >= 11'(cfg.quiet_width))
              && (in_data_i.column < sym_end);
    ok_d    = (in_data_i.digit_0 <= 4'd9) && (in_data_i.digit_1 <= 4'd9)
           && (in_data_i.digit_2 <= 4'd9) && (in_data_i.digit_3 <= 4'd9)
           && (in_data_i.digit_4 <= 4'd9) && (in_data_i.digit_5 <= 4'd9)
           && (in_data_i.digit_6 <= 4'd9) && (in_data_i.digit_7 <= 4'd9);
    sum_d   = 8'(in_data_i.digit_0) * 8'd3 + 8'(in_data_i.digit_1)
            + 8'(in_data_i.digit_2) * 8'd3 + 8'(in_data_i.digit_3)
            + 8'(in_data_i.digit_4) * 8'd3 + 8'(in_data_i.digit_5)
            + 8'(in_data_i.digit_6) * 8'd3;
  end

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dig1_q   <= {in_data_i.digit_0, in_data_i.digit_1, in_data_i.digit_2,
                   in_data_i.digit_3, in_data_i.digit_4, in_data_i.digit_5,
                   in_data_i.digit_6, in_data_i.digit_7};
      ok1_q    <= ok_d;
      sum1_q   <= sum_d;
      off1_q   <= in_data_i.column - 11'(cfg.quiet_width);
      mw1_q    <= mw_eff;
      insym1_q <= insym_d;
      oor1_q   <= oor_d;
    end
  end

  // ---------------- stage 2 ----------------
  assign prod_mod = 28'(off1_q) * 28'(recip16(mw1_q));
  assign prod_ten = 16'(sum1_q) * 16'd205;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      dig2_q   <= dig1_q;
      ok2_q    <= ok1_q;
      sum2_q   <= sum1_q;
      q10_q    <= prod_ten[15:11];
      mod_q    <= prod_mod[22:16];
      insym2_q <= insym1_q;
      oor2_q   <= oor1_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic [3:0] dig [8];
  logic [7:0] rem8;
  logic [3:0] expect_d;
  logic [4:0] k;
  logic [1:0] grp;
  logic [2:0] pos;
  logic [6:0] bits;
  logic       mbit;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dig[i] = dig2_q[31-4*i -: 4];
    end
    rem8     = sum2_q - 8'(q10_q) * 8'd10;
    expect_d = (rem8[3:0] == 4'd0) ? 4'd0 : 4'd10 - rem8[3:0];

    if (mod_q < 7'd31) begin
      k = 5'(mod_q - 7'd3);
    end else begin
      k = 5'(mod_q - 7'd36);
    end
    if (k >= 5'd21) begin
      grp = 2'd3;
    end else if (k >= 5'd14) begin
      grp = 2'd2;
    end else if (k >= 5'd7) begin
      grp = 2'd1;
    end else begin
      grp = 2'd0;
    end
    pos  = 3'(k - 5'(grp) * 5'd7);
    bits = lcode((mod_q < 7'd31) ? dig[{1'b0, grp}] : dig[{1'b1, grp}]);

    if (mod_q < 7'd3) begin
      mbit = (mod_q != 7'd1);
    end else if (mod_q < 7'd31) begin
      mbit = bits[3'd6 - pos];
    end else if (mod_q < 7'd36) begin
      mbit = ~mod_q[0];
    end else if (mod_q < 7'd64) begin
      mbit = ~bits[3'd6 - pos];
    end else begin
      mbit = (mod_q != 7'd65);
    end

    out_d.pixel        = insym2_q && ok2_q && mbit;
    out_d.check_ok     = ok2_q && (expect_d == dig[7]);
    out_d.in_symbol    = insym2_q;
    out_d.out_of_range = oor2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.in_symbol && out_data_o.out_of_range))
    else $error("in_symbol and out_of_range both set");

  a_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel |-> out_data_o.in_symbol)
    else $error("dark pixel outside symbol");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && out_valid_o && !out_ready_i))
    else $error("input stalled with room in pipeline");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted beat not captured");

endmodule

>>> src/ean8_cfg.sv
// APB register file: quiet zone width and module width.
module ean8_cfg import ean8_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [7:0] quiet_q;
  logic [4:0] module_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q  <= QuietReset;
      module_q <= ModuleReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegQuietWidth:  quiet_q  <= pwdata[7:0];
        RegModuleWidth: module_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegQuietWidth:  prdata = {24'd0, quiet_q};
      RegModuleWidth: prdata = {27'd0, module_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.quiet_width  = quiet_q;
  assign cfg_o.module_width = module_q;

endmodule
